[rtl/etlm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etlm_pkg: shared types and constants for the ETag list matcher
// Opcodes, character codes, counter widths and the stage-1 word layout.
// ----------------------------------------------------------------------------
package etlm_pkg;

	localparam int TAG_DEPTH = 64;
	// token position saturates here
	localparam int POS_CAP   = TAG_DEPTH + 3;
	// wide enough for tag length, position and stripped index (pos + 2)
	localparam int CNT_W     = $clog2(TAG_DEPTH + 5);
	localparam int ADDR_W    = $clog2(TAG_DEPTH);

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_W     = 8'h57;
	localparam logic [7:0] CH_SLASH = 8'h2F;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_TAG   = 2'd1,
		OP_HDR   = 2'd2,
		OP_END   = 2'd3
	} op_t;

	// progress through a leading W/ of a token
	typedef enum logic [1:0] {
		PFX_NONE  = 2'd0,
		PFX_W     = 2'd1,
		PFX_WS    = 2'd2
	} pfx_t;

	// one word in stage 1, with its precomputed compare qualifiers
	typedef struct packed {
		op_t              op;
		logic [7:0]       data;
		logic             act;          // byte lands at a token position
		logic             start;        // byte opens a new token
		logic             comma_end;    // comma closes the open token
		logic             blank;
		logic             pos_ok;       // position below the cap
		logic             pa_ok;        // plain index inside the tag
		logic             sb_chk;       // stripped lane compares this byte
		logic             sb_ok;        // stripped index inside the tag
		logic [CNT_W-1:0] new_pos;
		logic             end_inside;   // token open when the word arrived
		logic             end_ovf;
		logic             end_tag_weak;
		logic [CNT_W-1:0] end_tlen;
		logic             end_tok_pfx;  // token began with W/
	} s1_t;

	typedef struct packed {
		logic found;
		logic tag_overflow;
	} res_t;

endpackage

[rtl/etag_list_match_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etag_list_match_top: streamed HTTP ETag list matcher
// Matches If-Match / If-None-Match header lists against a stored entity tag.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): one word per opcode. Clear drops the tag and match
//   state, tag words append to the tag store (64 bytes), header words feed
//   the list one byte at a time, and an end word closes the list.
//   Output stream (m_*): one word per end word, carrying found and
//   tag_overflow. No other opcode produces output.
//   Configuration: cfg_we writes weak_equivalence; the user must write it
//   only while the block is idle, as the block has no check for this.
//   Throughput: one input word per cycle unless stalled. Every word takes
//   one pass: stage 1 holds the word with its two tag-store reads (plain
//   and stripped index), the judge updates the lanes, and the output
//   register holds the result; m_tvalid rises when an end word loads it.
//   Stall: while m_tready is low input words keep flowing until an end word
//   reaches stage 1 with the output register still full; s_tready then
//   drops until the waiting result is taken.
//   Reset: arst_n clears the tag length, token state, match flag, the
//   register and both valid flags; the tag store holds no reset value and
//   is only compared below the current tag length.
// ----------------------------------------------------------------------------
module etag_list_match_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [1:0] opcode, [9:2] data_byte, [15:10] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [0] found, [1] tag_overflow, [7:2] zero
	input  logic        cfg_we,
	input  logic        cfg_wdata
);

	localparam int CW = etlm_pkg::CNT_W;
	localparam int AW = etlm_pkg::ADDR_W;

	// front state: advances as each word is accepted
	logic [CW-1:0]       tag_len_q;
	logic                ovf_q;
	logic                inside_q;
	logic [CW-1:0]       pos_q;
	etlm_pkg::pfx_t      pfx_q;
	logic [7:0]          tag0_q, tag1_q;
	logic                weak_eq_q;

	// tag store
	logic [7:0]          mem [etlm_pkg::TAG_DEPTH];
	logic [7:0]          rd_a_s1, rd_b_s1;

	// stage 1 and output register
	etlm_pkg::s1_t       s1_s1;
	logic                valid_s1;
	logic                out_valid_q;
	etlm_pkg::res_t      out_q;

	logic                accept, advance;
	etlm_pkg::op_t       op;
	logic [7:0]          byte_in;
	etlm_pkg::s1_t       s1_d;
	etlm_pkg::res_t      res;
	logic                tag_weak, blank, comma;
	logic [CW-1:0]       p, idx_b;
	etlm_pkg::pfx_t      pfx_base;
	logic [CW-1:0]       tag_len_d, pos_d;
	logic                ovf_d, inside_d;
	etlm_pkg::pfx_t      pfx_d;

	assign op       = etlm_pkg::op_t'(s_tdata[1:0]);
	assign byte_in  = s_tdata[9:2];
	assign tag_weak = (tag_len_q >= CW'(2)) && (tag0_q == etlm_pkg::CH_W) &&
	                  (tag1_q == etlm_pkg::CH_SLASH);

	// an end word in stage 1 waits only for a free output register
	assign advance  = valid_s1 &&
	                  ((s1_s1.op != etlm_pkg::OP_END) || !out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign accept   = s_tvalid && s_tready;

	// front: classify the byte, track position and W/ prefix, pick indexes
	always_comb begin
		blank    = (byte_in == etlm_pkg::CH_SPACE) || (byte_in == etlm_pkg::CH_TAB);
		comma    = (byte_in == etlm_pkg::CH_COMMA);

		s1_d              = '0;
		s1_d.op           = op;
		s1_d.data         = byte_in;
		s1_d.blank        = blank;
		s1_d.end_inside   = inside_q;
		s1_d.end_ovf      = ovf_q;
		s1_d.end_tag_weak = tag_weak;
		s1_d.end_tlen     = tag_len_q;
		s1_d.end_tok_pfx  = (pfx_q == etlm_pkg::PFX_WS);

		tag_len_d = tag_len_q;
		ovf_d     = ovf_q;
		inside_d  = inside_q;
		pos_d     = pos_q;
		pfx_d     = pfx_q;

		s1_d.start     = !inside_q && !blank && !comma;
		s1_d.comma_end = inside_q && comma;
		s1_d.act       = s1_d.start || (inside_q && !comma);

		p        = s1_d.start ? '0 : pos_q;
		pfx_base = s1_d.start ? etlm_pkg::PFX_NONE : pfx_q;
		idx_b    = tag_weak ? (p + CW'(2)) : (p - CW'(2));

		s1_d.pos_ok  = (p < CW'(etlm_pkg::POS_CAP));
		s1_d.pa_ok   = (p < tag_len_q);
		s1_d.sb_chk  = tag_weak || (p >= CW'(2));
		s1_d.sb_ok   = (idx_b < tag_len_q);
		s1_d.new_pos = s1_d.pos_ok ? (p + CW'(1)) : p;

		case (op)
			etlm_pkg::OP_CLEAR: begin
				tag_len_d = '0;
				ovf_d     = 1'b0;
				inside_d  = 1'b0;
				pos_d     = '0;
				pfx_d     = etlm_pkg::PFX_NONE;
			end
			etlm_pkg::OP_TAG: begin
				if (tag_len_q < CW'(etlm_pkg::TAG_DEPTH))
					tag_len_d = tag_len_q + CW'(1);
				else
					ovf_d = 1'b1;
			end
			etlm_pkg::OP_HDR: begin
				if (s1_d.comma_end) begin
					inside_d = 1'b0;
					pos_d    = '0;
					pfx_d    = etlm_pkg::PFX_NONE;
				end else if (s1_d.act) begin
					inside_d = 1'b1;
					pos_d    = s1_d.new_pos;
					pfx_d    = pfx_base;
					if (s1_d.pos_ok) begin
						if (p == CW'(0))
							pfx_d = (byte_in == etlm_pkg::CH_W) ?
							        etlm_pkg::PFX_W : etlm_pkg::PFX_NONE;
						else if (p == CW'(1))
							pfx_d = (pfx_base == etlm_pkg::PFX_W &&
							         byte_in == etlm_pkg::CH_SLASH) ?
							        etlm_pkg::PFX_WS : etlm_pkg::PFX_NONE;
					end
				end
			end
			etlm_pkg::OP_END: begin
				inside_d = 1'b0;
				pos_d    = '0;
				pfx_d    = etlm_pkg::PFX_NONE;
			end
			default: begin
			end
		endcase
	end

	// front state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_len_q <= '0;
			ovf_q     <= 1'b0;
			inside_q  <= 1'b0;
			pos_q     <= '0;
			pfx_q     <= etlm_pkg::PFX_NONE;
		end else if (accept) begin
			tag_len_q <= tag_len_d;
			ovf_q     <= ovf_d;
			inside_q  <= inside_d;
			pos_q     <= pos_d;
			pfx_q     <= pfx_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			weak_eq_q <= 1'b0;
		else if (cfg_we)
			weak_eq_q <= cfg_wdata;
	end

	// keep the first two tag bytes at hand for the W/ test
	always_ff @(posedge clk) begin
		if (accept && op == etlm_pkg::OP_TAG) begin
			if (tag_len_q == CW'(0))
				tag0_q <= byte_in;
			if (tag_len_q == CW'(1))
				tag1_q <= byte_in;
		end
	end

	// tag store: write at the tail, read both lanes as the word enters stage 1
	always_ff @(posedge clk) begin
		if (accept && op == etlm_pkg::OP_TAG &&
		    tag_len_q < CW'(etlm_pkg::TAG_DEPTH))
			mem[tag_len_q[AW-1:0]] <= byte_in;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_a_s1 <= mem[p[AW-1:0]];
			rd_b_s1 <= mem[idx_b[AW-1:0]];
		end
	end

	// stage 1 payload and valid
	always_ff @(posedge clk) begin
		if (accept)
			s1_s1 <= s1_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	etlm_judge u_judge (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.s1      (s1_s1),
		.rd_a    (rd_a_s1),
		.rd_b    (rd_b_s1),
		.weak_eq (weak_eq_q),
		.res     (res)
	);

	// output register: load on an end word, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance && s1_s1.op == etlm_pkg::OP_END)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance && s1_s1.op == etlm_pkg::OP_END)
			out_q <= res;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'b0, out_q.tag_overflow, out_q.found};

`ifndef SYNTHESIS
	a_no_found_on_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
		else $error("found reported with tag overflow");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && s1_s1.op == etlm_pkg::OP_END && out_valid_q))
		else $error("input stalled without a blocked end word");

	a_pos_cap: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= CW'(etlm_pkg::POS_CAP))
		else $error("token position beyond cap");

	a_len_cap: assert property (@(posedge clk) disable iff (!arst_n)
		tag_len_q <= CW'(etlm_pkg::TAG_DEPTH))
		else $error("tag length beyond store depth");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> (tag_len_q == CW'(etlm_pkg::TAG_DEPTH)))
		else $error("overflow set with store not full");
`endif

endmodule

[rtl/etlm_judge.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etlm_judge: per-token compare lanes and match decision
// Runs the plain and stripped lanes on stage-1 words and judges tokens.
// ----------------------------------------------------------------------------
module etlm_judge (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  etlm_pkg::s1_t       s1,
	input  logic [7:0]          rd_a,
	input  logic [7:0]          rd_b,
	input  logic                weak_eq,
	output etlm_pkg::res_t      res
);

	logic                       plain_q, strip_q, match_q;
	logic [1:0]                 lsf_q;
	logic [etlm_pkg::CNT_W-1:0] lsl_q;

	logic                       plain_d, strip_d, match_d;
	logic [1:0]                 lsf_d;
	logic [etlm_pkg::CNT_W-1:0] lsl_d;
	logic                       tok_weak, cond, pl, st;

	always_comb begin
		tok_weak = s1.end_tok_pfx && (lsl_q >= etlm_pkg::CNT_W'(2));
		if (!s1.end_inside || s1.end_ovf) begin
			cond = 1'b0;
		end else if (!weak_eq || (s1.end_tag_weak == tok_weak)) begin
			cond = lsf_q[0] && (lsl_q == s1.end_tlen);
		end else if (tok_weak) begin
			cond = lsf_q[1] && (lsl_q == s1.end_tlen + etlm_pkg::CNT_W'(2));
		end else begin
			cond = lsf_q[1] && (s1.end_tlen >= etlm_pkg::CNT_W'(2)) &&
			       (lsl_q == s1.end_tlen - etlm_pkg::CNT_W'(2));
		end

		pl = s1.start ? 1'b1 : plain_q;
		st = s1.start ? 1'b1 : strip_q;
		if (!s1.pos_ok) begin
			pl = 1'b0;
			st = 1'b0;
		end else begin
			if (!(s1.pa_ok && rd_a == s1.data))
				pl = 1'b0;
			if (s1.sb_chk && !(s1.sb_ok && rd_b == s1.data))
				st = 1'b0;
		end

		plain_d = plain_q;
		strip_d = strip_q;
		match_d = match_q;
		lsf_d   = lsf_q;
		lsl_d   = lsl_q;
		case (s1.op)
			etlm_pkg::OP_CLEAR, etlm_pkg::OP_END: begin
				plain_d = 1'b1;
				strip_d = 1'b1;
				lsf_d   = 2'b00;
				lsl_d   = '0;
				match_d = 1'b0;
			end
			etlm_pkg::OP_HDR: begin
				if (s1.comma_end) begin
					match_d = match_q | cond;
					plain_d = 1'b1;
					strip_d = 1'b1;
					lsf_d   = 2'b00;
					lsl_d   = '0;
				end else if (s1.act) begin
					plain_d = pl;
					strip_d = st;
					if (!s1.blank) begin
						lsl_d = s1.new_pos;
						lsf_d = {st, pl};
					end
				end
			end
			default: begin
			end
		endcase

		res.found        = (match_q | cond) && !s1.end_ovf;
		res.tag_overflow = s1.end_ovf;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plain_q <= 1'b1;
			strip_q <= 1'b1;
			match_q <= 1'b0;
			lsf_q   <= 2'b00;
			lsl_q   <= '0;
		end else if (advance) begin
			plain_q <= plain_d;
			strip_q <= strip_d;
			match_q <= match_d;
			lsf_q   <= lsf_d;
			lsl_q   <= lsl_d;
		end
	end

endmodule

[dv/etag_list_match_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etag_list_match_checker: scoreboard for the ETag list matcher
// Follows every accepted input word and register write with its own copy of
// the tag store, token state and match flag. Compares each result word with
// the oldest predicted verdict.
// ----------------------------------------------------------------------------
module etag_list_match_checker
	import etlm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,   // [1:0] opcode, [9:2] data_byte
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,   // [0] found, [1] tag_overflow
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	output int          errors,
	output int          pending,
	output int          verdicts,
	output int          hits,
	output int          overflows
);

	logic [7:0]       tag_mem [TAG_DEPTH];
	logic [CNT_W-1:0] tag_len;
	logic             tag_ovf;
	logic             in_token;
	logic [CNT_W-1:0] tok_pos;
	logic             plain_ok;
	logic             strip_ok;
	pfx_t             tok_pfx;
	logic [CNT_W-1:0] solid_len;
	logic             solid_plain;
	logic             solid_strip;
	logic             list_hit;
	logic             weak_mode;
	res_t             verdict_q [$];

	initial begin
		errors    = 0;
		pending   = 0;
		verdicts  = 0;
		hits      = 0;
		overflows = 0;
	end

	task automatic report(string what, logic [7:0] want, logic [7:0] got);
		if (errors < 40)
			$display("[%0t] mismatch on %s: expected %h, got %h", $time, what, want, got);
		errors++;
	endtask

	function automatic logic tag_is_weak();
		return tag_len >= 2 && tag_mem[0] == CH_W && tag_mem[1] == CH_SLASH;
	endfunction

	task automatic drop_token();
		in_token    = 1'b0;
		tok_pos     = '0;
		plain_ok    = 1'b1;
		strip_ok    = 1'b1;
		tok_pfx     = PFX_NONE;
		solid_len   = '0;
		solid_plain = 1'b0;
		solid_strip = 1'b0;
	endtask

	// judge the token as it stood after its last non-blank byte
	function automatic logic token_equals_tag();
		int   len;
		int   tlen;
		logic tag_weak;
		logic tok_weak;
		len  = int'(solid_len);
		tlen = int'(tag_len);
		if (!in_token || tag_ovf)
			return 1'b0;
		tag_weak = tag_is_weak();
		tok_weak = tok_pfx == PFX_WS && len >= 2;
		if (!weak_mode || tag_weak == tok_weak)
			return solid_plain && len == tlen;
		if (tok_weak)
			return solid_strip && len == tlen + 2;
		return solid_strip && tlen >= 2 && len == tlen - 2;
	endfunction

	task automatic close_token();
		if (token_equals_tag())
			list_hit = 1'b1;
		drop_token();
	endtask

	task automatic feed_header_byte(logic [7:0] b);
		logic blank;
		int   pos;
		int   idx;
		int   tlen;
		blank = b == CH_SPACE || b == CH_TAB;
		tlen  = int'(tag_len);
		if (!in_token) begin
			if (blank || b == CH_COMMA)
				return;
			drop_token();
			in_token = 1'b1;
		end else if (b == CH_COMMA) begin
			close_token();
			return;
		end
		pos = int'(tok_pos);
		if (pos >= POS_CAP) begin
			plain_ok = 1'b0;
			strip_ok = 1'b0;
		end else begin
			if (!(pos < tlen && tag_mem[ADDR_W'(pos)] == b))
				plain_ok = 1'b0;
			// stripped lane: skip W/ of the tag, or of the token
			if (tag_is_weak()) begin
				idx = pos + 2;
				if (!(idx < tlen && tag_mem[ADDR_W'(idx)] == b))
					strip_ok = 1'b0;
			end else if (pos >= 2) begin
				idx = pos - 2;
				if (!(idx < tlen && tag_mem[ADDR_W'(idx)] == b))
					strip_ok = 1'b0;
			end
			if (pos == 0)
				tok_pfx = (b == CH_W) ? PFX_W : PFX_NONE;
			else if (pos == 1)
				tok_pfx = (tok_pfx == PFX_W && b == CH_SLASH) ? PFX_WS : PFX_NONE;
			tok_pos = CNT_W'(pos + 1);
		end
		if (!blank) begin
			solid_len   = tok_pos;
			solid_plain = plain_ok;
			solid_strip = strip_ok;
		end
	endtask

	task automatic apply_word(op_t op, logic [7:0] b);
		res_t r;
		case (op)
			OP_CLEAR: begin
				tag_len  = '0;
				tag_ovf  = 1'b0;
				list_hit = 1'b0;
				drop_token();
			end
			OP_TAG: begin
				if (tag_len < TAG_DEPTH) begin
					tag_mem[tag_len[ADDR_W-1:0]] = b;
					tag_len = tag_len + CNT_W'(1);
				end else begin
					tag_ovf = 1'b1;
				end
			end
			OP_HDR: feed_header_byte(b);
			default: begin
				close_token();
				r.found        = list_hit && !tag_ovf;
				r.tag_overflow = tag_ovf;
				verdict_q.push_back(r);
				list_hit = 1'b0;
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		res_t want;
		if (!arst_n) begin
			foreach (tag_mem[i])
				tag_mem[i] = '0;
			tag_len   = '0;
			tag_ovf   = 1'b0;
			list_hit  = 1'b0;
			weak_mode = 1'b0;
			drop_token();
			verdict_q.delete();
		end else begin
			if (cfg_we)
				weak_mode = cfg_wdata;
			if (s_tvalid && s_tready)
				apply_word(op_t'(s_tdata[1:0]), s_tdata[9:2]);
			if (m_tvalid && m_tready) begin
				if (verdict_q.size() == 0) begin
					report("unexpected result word", 8'h00, m_tdata);
				end else begin
					want = verdict_q.pop_front();
					verdicts++;
					if (want.found)
						hits++;
					if (want.tag_overflow)
						overflows++;
					if (m_tdata[0] !== want.found)
						report("found", {7'b0, want.found}, {7'b0, m_tdata[0]});
					if (m_tdata[1] !== want.tag_overflow)
						report("tag_overflow", {7'b0, want.tag_overflow},
							{7'b0, m_tdata[1]});
				end
			end
		end
		pending = verdict_q.size();
	end

endmodule

[dv/etag_list_match_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// etag_list_match_top_tb: stream test of the ETag list matcher
// Runs a short directed sequence, then random tags, header lists, noise and
// mode switches with random gaps on both sides; the checker predicts every
// result word and counts mismatches.
// ----------------------------------------------------------------------------
module etag_list_match_top_tb;
	import etlm_pkg::*;

	localparam int ITEMS        = 950;
	localparam int CYCLE_LIMIT  = 200000;
	// margin after the last result is taken, for the pipeline to drain
	localparam int DRAIN_CYCLES = 6;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;
	logic        cfg_we;
	logic        cfg_wdata;

	int errors;
	int pending;
	int verdicts;
	int hits;
	int overflows;

	int words_sent  = 0;
	int mode_writes = 0;
	int cycle_count = 0;
	// when set, both sides run without gaps
	bit calm = 1'b0;

	// bytes of the current tag and of the header line being built
	logic [7:0] tag_q  [$];
	logic [7:0] line_q [$];

	etag_list_match_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	etag_list_match_checker u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.errors    (errors),
		.pending   (pending),
		.verdicts  (verdicts),
		.hits      (hits),
		.overflows (overflows)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	// hard stop in case the block hangs
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("timeout after %0d cycles, %0d results still open", cycle_count, pending);
		$display("end of test: mismatches");
		$finish;
	end

	function automatic int draw_gap();
		return calm ? 0 : $urandom_range(0, 5);
	endfunction

	// mostly characters that steer the parser, the rest any byte
	function automatic logic [7:0] pick_char();
		case ($urandom_range(0, 9))
			0: return CH_W;
			1: return CH_SLASH;
			2: return CH_SPACE;
			3: return CH_TAB;
			4: return CH_COMMA;
			5, 6: return 8'h61 + 8'($urandom_range(0, 2));
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [7:0] pick_blank();
		return $urandom_range(0, 1) ? CH_SPACE : CH_TAB;
	endfunction

	// Enter just after a falling edge; return just after the falling edge
	// that follows the accepting rising edge, valid still high.
	task automatic send_word(op_t op, logic [7:0] b);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {6'b0, b, op};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		words_sent++;
	endtask

	task automatic send_text(op_t op, string s);
		for (int i = 0; i < s.len(); i++)
			send_word(op, s[i]);
	endtask

	// drop valid and let every open result and the pipeline drain
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic set_weak(logic v);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk) cfg_we <= 1'b0;
		mode_writes++;
	endtask

	// clear, then load a tag of len bytes, sometimes led by W/
	task automatic new_tag(int len);
		logic [7:0] b;
		send_word(OP_CLEAR, 8'($urandom_range(0, 255)));
		tag_q.delete();
		if (len >= 2 && $urandom_range(0, 2) == 0) begin
			tag_q.push_back(CH_W);
			tag_q.push_back(CH_SLASH);
		end
		while (tag_q.size() < len) begin
			b = ($urandom_range(0, 3) != 0) ? 8'h61 + 8'($urandom_range(0, 2))
			                                : 8'($urandom_range(0, 255));
			tag_q.push_back(b);
		end
		foreach (tag_q[i])
			send_word(OP_TAG, tag_q[i]);
	endtask

	// append one token with optional leading separators and trailing blanks
	task automatic add_token();
		int kind;
		int n;
		int pos;
		kind = $urandom_range(0, 19);
		n = $urandom_range(0, 2);
		repeat (n)
			line_q.push_back(($urandom_range(0, 2) == 0) ? CH_COMMA : pick_blank());
		if (kind <= 5) begin
			// exact copy of the tag
			foreach (tag_q[i])
				line_q.push_back(tag_q[i]);
		end else if (kind <= 8) begin
			// weak form of the tag
			line_q.push_back(CH_W);
			line_q.push_back(CH_SLASH);
			foreach (tag_q[i])
				line_q.push_back(tag_q[i]);
		end else if (kind <= 10) begin
			// tag with its first two bytes dropped
			foreach (tag_q[i])
				if (i >= 2)
					line_q.push_back(tag_q[i]);
		end else if (kind <= 12) begin
			// near miss: one byte changed, or one byte short
			pos = (tag_q.size() > 0) ? $urandom_range(0, tag_q.size() - 1) : -1;
			foreach (tag_q[i])
				if (i != pos)
					line_q.push_back(tag_q[i]);
				else if (kind == 11)
					line_q.push_back(tag_q[i] ^ 8'h01);
		end else if (kind == 13) begin
			// long token: tag then filler to a length near or past the position cap
			n = $urandom_range(62, 72);
			foreach (tag_q[i])
				if (i < n)
					line_q.push_back(tag_q[i]);
			for (int i = tag_q.size(); i < n; i++)
				line_q.push_back(8'h61 + 8'($urandom_range(0, 2)));
		end else begin
			n = $urandom_range(1, 6);
			repeat (n)
				line_q.push_back(pick_char());
		end
		n = $urandom_range(0, 2);
		repeat (n)
			line_q.push_back(pick_blank());
	endtask

	task automatic build_line(int ntok);
		line_q.delete();
		for (int i = 0; i < ntok; i++) begin
			add_token();
			if (i < ntok - 1 || $urandom_range(0, 5) == 0)
				line_q.push_back(CH_COMMA);
		end
	endtask

	task automatic send_list();
		build_line($urandom_range(0, 4));
		foreach (line_q[i])
			send_word(OP_HDR, line_q[i]);
		send_word(OP_END, 8'($urandom_range(0, 255)));
	endtask

	// receive side: hold ready low for a drawn number of cycles per result
	initial begin : rx_side
		int hold;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			hold = draw_gap();
			if (hold > 0) begin
				@(negedge clk) m_tready <= 1'b0;
				repeat (hold - 1) @(negedge clk);
			end
			@(negedge clk) m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	initial begin : stimulus
		int len;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		cfg_we    = 1'b0;
		cfg_wdata = 1'b0;
		arst_n    = 1'b0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: strict mode, the weak token matches the weak tag,
		// blanks, tabs and leading commas are skipped
		set_weak(1'b0);
		send_word(OP_CLEAR, 8'hFF);
		send_text(OP_TAG, "W/x");
		send_text(OP_HDR, "\t,x ,W/x\t");
		send_word(OP_END, 8'h00);
		// weak mode: plain token against the weak tag
		set_weak(1'b1);
		send_text(OP_HDR, "x");
		send_word(OP_END, 8'hFF);
		// extreme tag byte, then an empty list
		send_word(OP_TAG, 8'hFF);
		send_word(OP_HDR, 8'h78);
		send_word(OP_HDR, 8'hFF);
		send_word(OP_END, 8'h00);
		send_word(OP_END, 8'h55);
		// zero bytes compare like any other
		send_word(OP_CLEAR, 8'h00);
		send_word(OP_TAG, 8'h00);
		send_word(OP_HDR, 8'h00);
		send_word(OP_END, 8'hAA);

		// random part: always start from a fresh tag
		new_tag($urandom_range(1, 6));
		while (words_sent < ITEMS + 25) begin
			if ($urandom_range(0, 31) == 0)
				calm = !calm;
			case ($urandom_range(0, 19))
				0, 1: new_tag($urandom_range(0, 8));
				2: begin
					// near or past the store depth
					len = $urandom_range(60, 70);
					new_tag(len);
				end
				3: begin
					// noise: any opcode, any byte
					len = $urandom_range(1, 6);
					repeat (len)
						send_word(op_t'(2'($urandom_range(0, 3))),
							8'($urandom_range(0, 255)));
				end
				4: set_weak(1'($urandom_range(0, 1)));
				5: begin
					// change the tag or the mode with a token still open
					build_line(1);
					foreach (line_q[i])
						send_word(OP_HDR, line_q[i]);
					if ($urandom_range(0, 1)) begin
						len = $urandom_range(0, 255);
						send_word(OP_TAG, 8'(len));
						tag_q.push_back(8'(len));
					end else begin
						set_weak(1'($urandom_range(0, 1)));
					end
					send_list();
				end
				default: send_list();
			endcase
		end

		drain();
		$display("sent %0d words with %0d mode writes; checked %0d results,", words_sent,
			mode_writes, verdicts);
		$display("%0d of them matches and %0d with tag overflow", hits, overflows);
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
